FILE: rtl/core/tkpot_pkg.sv
// Shared widths and event codes for the two-key press order tracker.
package tkpot_pkg;

    localparam int WORD_W = 16;
    localparam int KEY_W  = 5;
    localparam int EVT_W  = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KEY_W-1:0]  t_key;

    typedef enum logic [EVT_W-1:0] {
        EV_OK        = 3'd0,
        EV_STUCK     = 3'd1,
        EV_NOT_FOUND = 3'd2,
        EV_FULL      = 3'd3,
        EV_NO_BIT    = 3'd4
    } t_event;

endpackage

FILE: rtl/core/tkpot_if.sv
// Valid/ready channel interfaces for the touch word input and the key list result.
interface tkpot_in_if;
    import tkpot_pkg::*;

    logic  valid;
    logic  ready;
    t_word touch_status;

    modport source (output valid, output touch_status, input ready);
    modport sink   (input valid, input touch_status, output ready);
endinterface

interface tkpot_out_if;
    import tkpot_pkg::*;

    logic   valid;
    logic   ready;
    t_key   first_key;
    t_key   second_key;
    logic   changed;
    t_event event_code;

    modport source (output valid, output first_key, output second_key,
                    output changed, output event_code, input ready);
    modport sink   (input valid, input first_key, input second_key,
                    input changed, input event_code, output ready);
endinterface

FILE: rtl/core/two_key_press_order_tracker_core.sv
// Two-key press order tracker: input register, combinational list update, result register.
//
//  channel | modport     | word contents                                   | accepted when
//  --------+-------------+-------------------------------------------------+--------------
//  i_in    | tkpot sink  | touch_status[15:0]                              | valid & ready
//  o_out   | tkpot source| first_key[4:0] second_key[4:0] changed event[2:0]| valid & ready
//
//  A word is held in the input register while the update logic works on
//  it, and its result is loaded into the output register once that register
//  is free or being drained; one word per clock is sustained while results
//  are drained. The rate is set by the update of the previous word and the
//  two key slots, which is combinational.
//  Reset (i_rst_n low, synchronous) empties both stages, clears the previous
//  word and both slots. A stalled result holds in the output register; the
//  input register still takes a word while it is empty or the output register
//  is free or being drained in the same cycle.
module two_key_press_order_tracker_core #(
    parameter int KEY_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkpot_in_if.sink    i_in,
    tkpot_out_if.source o_out
);
    import tkpot_pkg::*;

    // Touch bits at index KEY_COUNT and above are ignored.
    localparam t_word KEY_MASK = WORD_W'((33'd1 << KEY_COUNT) - 33'd1);

    // Lowest set bit as a key number, zero when the word is empty.
    function automatic t_key lowest_key(input t_word w);
        t_key k;
        k = '0;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (w[i]) begin
                k = KEY_W'(i + 1);
            end
        end
        return k;
    endfunction

    // Input stage
    logic   r_in_valid;
    t_word  r_in_word;

    // Tracker state
    t_word  r_prev;
    t_key   r_slot0;
    t_key   r_slot1;

    // Output stage
    logic   r_out_valid;
    t_key   r_out_first;
    t_key   r_out_second;
    logic   r_out_changed;
    t_event r_out_event;

    logic   out_adv;
    logic   upd_en;
    logic   in_take;

    t_word  delta;
    t_key   low_word;
    t_key   low_delta;
    logic   n_changed;
    t_event n_event;
    t_key   n_slot0;
    t_key   n_slot1;

    // Advance the update stage whenever the result register is free or drains.
    assign out_adv     = !r_out_valid || o_out.ready;
    assign upd_en      = r_in_valid && out_adv;
    assign i_in.ready  = !r_in_valid || out_adv;
    assign in_take     = i_in.valid && i_in.ready;

    assign delta     = r_prev ^ r_in_word;
    assign low_word  = lowest_key(r_in_word);
    assign low_delta = lowest_key(delta);
    assign n_changed = (r_in_word != r_prev);

    // List update for the word held in the input register.
    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_event = EV_OK;
        if (n_changed) begin
            if (r_slot0 == '0) begin
                // Empty list: add the lowest touched key.
                if (low_word == '0) begin
                    n_event = EV_NO_BIT;
                end else begin
                    n_slot0 = low_word;
                end
            end else if (r_in_word == '0) begin
                // Keys listed but nothing touched: drop the list as stuck.
                n_slot0 = '0;
                n_slot1 = '0;
                n_event = EV_STUCK;
            end else if ((delta & r_prev) != '0) begin
                // A release is present: remove the lowest changed key.
                if (low_delta == '0) begin
                    n_event = EV_NO_BIT;
                end else if (r_slot0 == low_delta) begin
                    n_slot0 = r_slot1;
                    n_slot1 = '0;
                end else if (r_slot1 == low_delta) begin
                    n_slot1 = '0;
                end else begin
                    n_event = EV_NOT_FOUND;
                end
            end else begin
                // Pure press: append the lowest new key.
                if (low_delta == '0) begin
                    n_event = EV_NO_BIT;
                end else if (r_slot1 == '0) begin
                    n_slot1 = low_delta;
                end else begin
                    n_event = EV_FULL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_slot0     <= '0;
            r_slot1     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (upd_en) begin
                r_in_valid <= 1'b0;
            end
            if (upd_en) begin
                r_out_valid <= 1'b1;
                r_prev      <= r_in_word;
                r_slot0     <= n_slot0;
                r_slot1     <= n_slot1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in.touch_status & KEY_MASK;
        end
        if (upd_en) begin
            r_out_first   <= n_slot0;
            r_out_second  <= n_slot1;
            r_out_changed <= n_changed;
            r_out_event   <= n_event;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.first_key  = r_out_first;
    assign o_out.second_key = r_out_second;
    assign o_out.changed    = r_out_changed;
    assign o_out.event_code = r_out_event;

    // The second slot is filled only behind the first.
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot1 != '0) |-> (r_slot0 != '0))
        else $error("second slot held while first slot empty");

    // Listed keys stay within the key range.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot0 <= KEY_W'(KEY_COUNT)) && (r_slot1 <= KEY_W'(KEY_COUNT)))
        else $error("slot holds a key number out of range");

    // A stuck clear always reports an empty list.
    a_stuck_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_event == EV_STUCK)) |->
        ((r_out_first == '0) && (r_out_second == '0)))
        else $error("stuck event with keys still listed");

    // An unchanged word never reports an event.
    a_quiet_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_changed) |-> (r_out_event == EV_OK))
        else $error("event reported for an unchanged word");

endmodule
